FILE: rtl/core/aes_pkg.sv
package aes_pkg;

  localparam int NumRounds = 14;
  localparam int NumRoundKeys = 15;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_ROUND,
    ST_DONE
  } state_t;

  typedef enum logic {
    REQ_ENCRYPT = 1'b0,
    REQ_DECRYPT = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    CFG_KEY0 = 2'd0,
    CFG_KEY1 = 2'd1,
    CFG_KEY2 = 2'd2,
    CFG_KEY3 = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic       first;
    logic       last;
    logic       decrypt;
  } round_ctl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage

FILE: rtl/core/aes256_block_cipher_core.sv
// Channel   Dir  Handshake           Payload
// in        in   in_valid/in_stall   req_type, block_hi, block_lo, last_block
// out       out  out_valid/out_stall result_hi, result_lo, last_out
// cfg       in   cfg_valid/cfg_ready cfg_index, cfg_data
// One block: accept, the shared round unit (key read, initial key add,
// 14 rounds) and the output register, in that order.
// After reset or a key write the first block first expands all 15 round keys.
// rst is synchronous; the round-key memory is not cleared.
// A stalled result holds in the output register; the next block runs meanwhile
// and waits after its last round until the register frees.
module aes256_block_cipher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [63:0] block_hi,
  input  logic [63:0] block_lo,
  input  logic        last_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_hi,
  output logic [63:0] result_lo,
  output logic        last_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import aes_pkg::*;

  state_t       state, state_next;
  logic [255:0] key;
  logic         keys_ready;
  logic [127:0] blk;
  logic         dec;
  logic         last_flag;
  logic [4:0]   step;
  logic [3:0]   rd_idx;
  logic [127:0] rkey;
  logic [127:0] round_out;
  logic         exp_start;
  logic         exp_done;
  round_ctl_t   ctl;
  logic         accept;
  logic         load;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign load      = (state == ST_DONE) && (!out_valid || !out_stall);
  assign exp_start = accept && !keys_ready;

  // step 0: memory read latency; steps 1..15 apply round keys
  always_comb begin
    if (dec) begin
      rd_idx = 4'(NumRounds) - step[3:0];
    end else begin
      rd_idx = step[3:0];
    end
    ctl.first   = (step == 5'd1);
    ctl.last    = (step == 5'(NumRoundKeys));
    ctl.decrypt = dec;
  end

  aes_key_exp u_kexp (
    .clk    (clk),
    .rst    (rst),
    .start  (exp_start),
    .key    (key),
    .done   (exp_done),
    .rd_idx (rd_idx),
    .rd_key (rkey)
  );

  aes_round u_round (
    .state_in  (blk),
    .rkey      (rkey),
    .ctl       (ctl),
    .state_out (round_out)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = keys_ready ? ST_ROUND : ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        if (exp_done) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (step == 5'(NumRoundKeys)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      keys_ready <= 1'b0;
      key        <= '0;
      step       <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        keys_ready <= 1'b0;
        unique case (cfg_idx_t'(cfg_index))
          CFG_KEY0: key[255:192] <= cfg_data;
          CFG_KEY1: key[191:128] <= cfg_data;
          CFG_KEY2: key[127:64]  <= cfg_data;
          CFG_KEY3: key[63:0]    <= cfg_data;
          default: ;
        endcase
      end else if (state == ST_EXPAND && exp_done) begin
        keys_ready <= 1'b1;
      end
      if (state != ST_ROUND || step == 5'(NumRoundKeys)) begin
        step <= '0;
      end else begin
        step <= step + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      blk       <= {block_hi, block_lo};
      dec       <= (req_t'(req_type) == REQ_DECRYPT);
      last_flag <= last_block;
    end else if (state == ST_ROUND && step != 5'd0) begin
      blk <= round_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_hi <= blk[127:64];
      result_lo <= blk[63:0];
      last_out  <= last_flag;
    end
  end

`ifndef SYNTHESIS
  a_load_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_valid && out_stall) |=> (state == ST_DONE))
    else $error("finished block dropped while result pending");
  a_round_needs_keys: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> keys_ready)
    else $error("rounds without expanded keys");
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    step <= 5'(NumRoundKeys))
    else $error("step counter overrun");
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(result_hi) && $stable(result_lo)))
    else $error("stalled result changed");
`endif

endmodule

FILE: rtl/core/aes_key_exp.sv
module aes_key_exp (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [255:0] key,
  output logic         done,
  input  logic [3:0]   rd_idx,
  output logic [127:0] rd_key
);
  import aes_pkg::*;

  // one 128-bit round key (four words) per cycle: alternating word groups
  logic [127:0] mem [NumRoundKeys];
  logic [255:0] win;
  logic [255:0] win_next;
  logic [7:0]   rcon;
  logic [3:0]   widx;
  logic         busy;
  logic [31:0]  w [8];
  logic [31:0]  t;
  logic [31:0]  n [4];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      w[i] = win[255 - 32*i -: 32];
    end
    // widx even: next group starts at i%8==0, odd: at i%8==4
    if (!widx[0]) begin
      t = sub_word({w[7][23:0], w[7][31:24]}) ^ {rcon, 24'h0};
    end else begin
      t = sub_word(w[7]);
    end
    n[0] = w[0] ^ t;
    n[1] = w[1] ^ n[0];
    n[2] = w[2] ^ n[1];
    n[3] = w[3] ^ n[2];
    win_next = {win[127:0], n[0], n[1], n[2], n[3]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      win  <= key;
      rcon <= 8'h01;
      widx <= 4'd0;
      busy <= 1'b1;
    end else if (busy) begin
      mem[widx] <= win[255:128];
      if (!widx[0]) begin
        rcon <= xtime(rcon);
      end
      win  <= win_next;
      widx <= widx + 4'd1;
      if (widx == 4'(NumRoundKeys - 1)) begin
        busy <= 1'b0;
      end
    end
    rd_key <= mem[rd_idx];
  end

  assign done = busy && (widx == 4'(NumRoundKeys - 1));

endmodule

FILE: rtl/core/aes_round.sv
module aes_round (
  input  logic [127:0]        state_in,
  input  logic [127:0]        rkey,
  input  aes_pkg::round_ctl_t ctl,
  output logic [127:0]        state_out
);
  import aes_pkg::*;

  logic [7:0] s [16];
  logic [7:0] a [16];
  logic [7:0] b [16];
  logic [7:0] m [16];
  logic [7:0] k [16];
  logic [7:0] x2, x4, x8, y0, y1, y2, y3;

  // first: key only; encrypt: sub, shift, mix (not last), key
  // decrypt: invshift, invsub, key, invmix (not last)
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_in[127 - 8*i -: 8];
      k[i] = rkey[127 - 8*i -: 8];
    end
    for (int i = 0; i < 16; i++) begin
      a[i] = '0;
      b[i] = '0;
      m[i] = '0;
    end
    x2 = '0; x4 = '0; x8 = '0;
    y0 = '0; y1 = '0; y2 = '0; y3 = '0;
    state_out = state_in;
    if (ctl.first) begin
      for (int i = 0; i < 16; i++) begin
        state_out[127 - 8*i -: 8] = s[i] ^ k[i];
      end
    end else if (!ctl.decrypt) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          a[r + 4*c] = sbox(s[r + 4*((c + r) % 4)]);
        end
      end
      for (int c = 0; c < 4; c++) begin
        y0 = a[4*c]; y1 = a[4*c+1]; y2 = a[4*c+2]; y3 = a[4*c+3];
        m[4*c]   = xtime(y0) ^ xtime(y1) ^ y1 ^ y2 ^ y3;
        m[4*c+1] = y0 ^ xtime(y1) ^ xtime(y2) ^ y2 ^ y3;
        m[4*c+2] = y0 ^ y1 ^ xtime(y2) ^ xtime(y3) ^ y3;
        m[4*c+3] = xtime(y0) ^ y0 ^ y1 ^ y2 ^ xtime(y3);
      end
      for (int i = 0; i < 16; i++) begin
        state_out[127 - 8*i -: 8] = (ctl.last ? a[i] : m[i]) ^ k[i];
      end
    end else begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          b[r + 4*((c + r) % 4)] = s[r + 4*c];
        end
      end
      for (int i = 0; i < 16; i++) begin
        a[i] = inv_sbox(b[i]) ^ k[i];
      end
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          y0 = a[4*c + ((r) % 4)];
          y1 = a[4*c + ((r + 1) % 4)];
          y2 = a[4*c + ((r + 2) % 4)];
          y3 = a[4*c + ((r + 3) % 4)];
          // 14*y0 ^ 11*y1 ^ 13*y2 ^ 9*y3
          x2 = xtime(y0); x4 = xtime(x2); x8 = xtime(x4);
          m[4*c+r] = x8 ^ x4 ^ x2;
          x2 = xtime(y1); x4 = xtime(x2); x8 = xtime(x4);
          m[4*c+r] = m[4*c+r] ^ x8 ^ x2 ^ y1;
          x2 = xtime(y2); x4 = xtime(x2); x8 = xtime(x4);
          m[4*c+r] = m[4*c+r] ^ x8 ^ x4 ^ y2;
          x2 = xtime(y3); x4 = xtime(x2); x8 = xtime(x4);
          m[4*c+r] = m[4*c+r] ^ x8 ^ y3;
        end
      end
      for (int i = 0; i < 16; i++) begin
        state_out[127 - 8*i -: 8] = ctl.last ? a[i] : m[i];
      end
    end
  end

endmodule
